// ===== hw/rtl/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg
// Types, register indexes and phase codes shared by the link frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

   localparam int WANTED_MAX_DEF = 8;
   localparam int FRAME_MAX_DEF  = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_BYTE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_BYTE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_BYTES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANTED_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_MODE   = 3'd4;

   localparam logic [7:0] FLAG_BYTE_RST    = 8'd126;
   localparam logic [7:0] ADDRESS_BYTE_RST = 8'd3;

   // rx_state codes as seen on the result channel
   localparam logic [2:0] RX_IDLE  = 3'd0;
   localparam logic [2:0] RX_FLAG  = 3'd1;
   localparam logic [2:0] RX_ADDR  = 3'd2;
   localparam logic [2:0] RX_CTRL  = 3'd3;
   localparam logic [2:0] RX_CHECK = 3'd4;
   localparam logic [2:0] RX_DONE  = 3'd5;

   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic MODE_SUPERVISION = 1'b0;
   localparam logic MODE_INFORMATION = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_FLAG  = 6'b000010,
      PH_ADDR  = 6'b000100,
      PH_CTRL  = 6'b001000,
      PH_CHECK = 6'b010000,
      PH_DONE  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] rx_state;
      logic       store_valid;
      logic [9:0] store_pos;
      logic [7:0] store_byte;
      logic       frame_done;
      logic [2:0] control_index;
      logic [9:0] payload_length;
      logic       overflow;
   } rsp_payload_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_IDLE:  code = RX_IDLE;
         PH_FLAG:  code = RX_FLAG;
         PH_ADDR:  code = RX_ADDR;
         PH_CTRL:  code = RX_CTRL;
         PH_CHECK: code = RX_CHECK;
         PH_DONE:  code = RX_DONE;
         default:  code = RX_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/link_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// link_frame_receiver_top
// Flag / address / control / check header tracker for a serial byte link.
// ----------------------------------------------------------------------------
// One request carries either a received byte or a restart command and gives
// exactly one response. The block takes a request every cycle unless req_stall
// is high. A request is registered in the input register, then the header
// compare (eight wanted control bytes in parallel) and phase update land in the
// response register. Both stages advance together whenever the response
// register is empty or being taken, so req_stall follows rsp_stall while a
// response waits. The user must write configuration registers only while no
// request is in flight; the block itself does not enforce it.
module link_frame_receiver_top #(
   parameter int WANTED_MAX = lfr_pkg::WANTED_MAX_DEF,
   parameter int FRAME_MAX  = lfr_pkg::FRAME_MAX_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lfr_pkg::req_payload_type               req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lfr_pkg::rsp_payload_type               rsp_payload,
   input  logic                                   csr_write,
   input  logic [lfr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [lfr_pkg::CSR_DATA_W-1:0]         csr_data
);
   import lfr_pkg::*;

   localparam int POS_W = $clog2(FRAME_MAX);
   localparam int EXT_W = (POS_W > 10) ? POS_W : 10;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_MAX - 1);
   localparam logic [3:0]       CNT_MAX  = 4'(WANTED_MAX);

   // configuration
   logic [7:0]  flag_byte_ff;
   logic [7:0]  address_byte_ff;
   logic [63:0] wanted_bytes_ff;
   logic [3:0]  wanted_count_ff;
   logic        frame_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_byte_ff    <= FLAG_BYTE_RST;
         address_byte_ff <= ADDRESS_BYTE_RST;
         wanted_bytes_ff <= '0;
         wanted_count_ff <= '0;
         frame_mode_ff   <= MODE_SUPERVISION;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FLAG_BYTE:    flag_byte_ff    <= csr_data[7:0];
            CSR_ADDRESS_BYTE: address_byte_ff <= csr_data[7:0];
            CSR_WANTED_BYTES: wanted_bytes_ff <= csr_data;
            CSR_WANTED_COUNT: wanted_count_ff <= csr_data[3:0];
            CSR_FRAME_MODE:   frame_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic            pipe_en;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && req_valid) begin
         in_data_ff <= req_payload;
      end
   end

   // frame state
   phase_type        phase_ff, phase_in;
   logic [7:0]       control_seen_ff, control_seen_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       midx_ff, midx_in;

   // wanted byte search, lowest index wins
   logic [7:0] cur_byte;
   logic [3:0] wanted_n;
   logic       wanted_hit;
   logic [2:0] wanted_idx;

   assign cur_byte = in_data_ff.data_byte;
   assign wanted_n = (wanted_count_ff > CNT_MAX) ? CNT_MAX : wanted_count_ff;

   always_comb begin
      wanted_hit = 1'b0;
      wanted_idx = '0;
      for (int k = WANTED_MAX - 1; k >= 0; k--) begin
         if ((4'(k) < wanted_n) && (wanted_bytes_ff[8*k +: 8] == cur_byte)) begin
            wanted_hit = 1'b1;
            wanted_idx = 3'(k);
         end
      end
   end

   logic             is_flag;
   logic             keep;
   logic             done;
   logic             ovf;
   logic [POS_W-1:0] kpos;
   logic [EXT_W-1:0] plen;
   logic [EXT_W-1:0] kpos_ext;
   logic [EXT_W-1:0] pos_ext;
   logic [2:0]       cidx;
   logic [POS_W-1:0] pos_inc;

   assign is_flag = (cur_byte == flag_byte_ff);
   assign pos_inc = pos_ff + 1'b1;
   assign pos_ext = EXT_W'(pos_ff);

   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      control_seen_in = control_seen_ff;
      midx_in         = midx_ff;
      keep            = 1'b0;
      done            = 1'b0;
      ovf             = 1'b0;
      kpos            = '0;
      plen            = '0;
      cidx            = '0;
      if (in_data_ff.cmd == CMD_RESTART) begin
         phase_in = PH_IDLE;
         pos_in   = '0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               pos_in = '0;
               if (is_flag) begin
                  keep     = 1'b1;
                  pos_in   = POS_W'(1);
                  phase_in = PH_FLAG;
               end
            end
            PH_FLAG: begin
               if (!is_flag) begin
                  if (cur_byte == address_byte_ff) begin
                     keep     = 1'b1;
                     kpos     = pos_ff;
                     pos_in   = pos_inc;
                     phase_in = PH_ADDR;
                  end else begin
                     phase_in = PH_IDLE;
                     pos_in   = '0;
                  end
               end
            end
            PH_ADDR: begin
               if (is_flag) begin
                  phase_in = PH_FLAG;
                  pos_in   = POS_W'(1);
               end else if (wanted_hit) begin
                  midx_in         = wanted_idx;
                  control_seen_in = cur_byte;
                  keep            = 1'b1;
                  kpos            = pos_ff;
                  pos_in          = pos_inc;
                  phase_in        = PH_CTRL;
               end else begin
                  phase_in = PH_IDLE;
                  pos_in   = '0;
               end
            end
            PH_CTRL: begin
               // check compare takes priority over the flag test
               if (cur_byte == (address_byte_ff ^ control_seen_ff)) begin
                  keep     = 1'b1;
                  kpos     = pos_ff;
                  pos_in   = pos_inc;
                  phase_in = PH_CHECK;
               end else if (is_flag) begin
                  phase_in = PH_FLAG;
                  pos_in   = POS_W'(1);
               end else begin
                  phase_in = PH_IDLE;
                  pos_in   = '0;
               end
            end
            PH_CHECK: begin
               if (is_flag) begin
                  keep     = 1'b1;
                  kpos     = pos_ff;
                  done     = 1'b1;
                  phase_in = PH_DONE;
                  if (frame_mode_ff == MODE_INFORMATION) begin
                     plen = (pos_ext >= EXT_W'(4)) ? pos_ext - EXT_W'(4) : '0;
                  end else begin
                     cidx = midx_ff;
                  end
               end else if (frame_mode_ff == MODE_INFORMATION) begin
                  // last slot is reserved for the closing flag
                  if (pos_ff >= POS_LAST) begin
                     ovf = 1'b1;
                  end else begin
                     keep   = 1'b1;
                     kpos   = pos_ff;
                     pos_in = pos_inc;
                  end
               end else begin
                  phase_in = PH_IDLE;
                  pos_in   = '0;
               end
            end
            PH_DONE: ;
            default: ;
         endcase
      end
   end

   assign kpos_ext = EXT_W'(kpos);

   always_comb begin
      rsp_payload_in                = '0;
      rsp_payload_in.rx_state       = phase_code(phase_in);
      rsp_payload_in.store_valid    = keep;
      rsp_payload_in.store_pos      = keep ? kpos_ext[9:0] : 10'd0;
      rsp_payload_in.store_byte     = keep ? cur_byte : 8'd0;
      rsp_payload_in.frame_done     = done;
      rsp_payload_in.control_index  = cidx;
      rsp_payload_in.payload_length = plen[9:0];
      rsp_payload_in.overflow       = ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         pos_ff          <= '0;
         control_seen_ff <= '0;
         midx_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            phase_ff        <= phase_in;
            pos_ff          <= pos_in;
            control_seen_ff <= control_seen_in;
            midx_ff         <= midx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && in_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (pos_ff == '0))
      else $error("position not cleared in idle phase");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("frame position beyond store");

   a_midx_bound: assert property (@(posedge clock) disable iff (reset)
      32'(midx_ff) < WANTED_MAX)
      else $error("matched index beyond wanted table");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.frame_done) |->
         (rsp_payload_ff.store_valid && rsp_payload_ff.rx_state == RX_DONE))
      else $error("frame done without kept closing flag");

   a_ovf_no_keep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.overflow) |->
         (!rsp_payload_ff.store_valid && rsp_payload_ff.rx_state == RX_CHECK))
      else $error("overflow with kept byte");

endmodule

// ===== verif/lfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_checker
// Watches the request, response and register ports of the link frame
// receiver. It keeps its own copy of the registers and of the header
// tracking state, works out the response for each accepted request, and
// compares every accepted response field by field, in order.
// ----------------------------------------------------------------------------
module lfr_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  lfr_pkg::req_payload_type        req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  lfr_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_write,
   input  logic [lfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfr_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              request_count,
   output int                              frame_count,
   output int                              overflow_count
);
   import lfr_pkg::*;

   logic [7:0]  flag_cfg;
   logic [7:0]  addr_cfg;
   logic [63:0] wanted_cfg;
   logic [3:0]  count_cfg;
   logic        mode_cfg;

   logic [2:0]  phase_now;
   logic [7:0]  ctrl_seen;
   int          frame_pos;
   logic [2:0]  match_idx;

   rsp_payload_type expected_rsp_q[$];

   // Header tracker: updates the phase state and returns the response
   // the block should give for this request.
   function automatic rsp_payload_type advance_receiver(input req_payload_type r);
      rsp_payload_type res;
      logic [7:0] b;
      logic       hit_flag;
      int         slots;
      int         hit;
      res = '0;
      b = r.data_byte;
      hit_flag = (b == flag_cfg);
      if (r.cmd == CMD_RESTART) begin
         phase_now = RX_IDLE;
         frame_pos = 0;
      end else begin
         case (phase_now)
            RX_IDLE: begin
               frame_pos = 0;
               if (hit_flag) begin
                  res.store_valid = 1'b1;
                  res.store_pos = '0;
                  res.store_byte = b;
                  frame_pos = 1;
                  phase_now = RX_FLAG;
               end
            end
            RX_FLAG: begin
               if (!hit_flag) begin
                  if (b == addr_cfg) begin
                     res.store_valid = 1'b1;
                     res.store_pos = 10'(frame_pos);
                     res.store_byte = b;
                     frame_pos++;
                     phase_now = RX_ADDR;
                  end else begin
                     phase_now = RX_IDLE;
                     frame_pos = 0;
                  end
               end
            end
            RX_ADDR: begin
               if (hit_flag) begin
                  phase_now = RX_FLAG;
                  frame_pos = 1;
               end else begin
                  // counts above the table size act as a full table
                  slots = (count_cfg > WANTED_MAX_DEF) ? WANTED_MAX_DEF : int'(count_cfg);
                  hit = -1;
                  for (int k = slots - 1; k >= 0; k--) begin
                     if (wanted_cfg[8*k +: 8] == b) hit = k;
                  end
                  if (hit >= 0) begin
                     match_idx = 3'(hit);
                     ctrl_seen = b;
                     res.store_valid = 1'b1;
                     res.store_pos = 10'(frame_pos);
                     res.store_byte = b;
                     frame_pos++;
                     phase_now = RX_CTRL;
                  end else begin
                     phase_now = RX_IDLE;
                     frame_pos = 0;
                  end
               end
            end
            RX_CTRL: begin
               // check compare wins over the flag test
               if (b == (addr_cfg ^ ctrl_seen)) begin
                  res.store_valid = 1'b1;
                  res.store_pos = 10'(frame_pos);
                  res.store_byte = b;
                  frame_pos++;
                  phase_now = RX_CHECK;
               end else if (hit_flag) begin
                  phase_now = RX_FLAG;
                  frame_pos = 1;
               end else begin
                  phase_now = RX_IDLE;
                  frame_pos = 0;
               end
            end
            RX_CHECK: begin
               if (hit_flag) begin
                  res.store_valid = 1'b1;
                  res.store_pos = 10'(frame_pos);
                  res.store_byte = b;
                  res.frame_done = 1'b1;
                  phase_now = RX_DONE;
                  if (mode_cfg == MODE_INFORMATION)
                     res.payload_length = 10'((frame_pos >= 4) ? frame_pos - 4 : 0);
                  else
                     res.control_index = match_idx;
               end else if (mode_cfg == MODE_INFORMATION) begin
                  // last slot is held back for the closing flag
                  if (frame_pos >= FRAME_MAX_DEF - 1) begin
                     res.overflow = 1'b1;
                  end else begin
                     res.store_valid = 1'b1;
                     res.store_pos = 10'(frame_pos);
                     res.store_byte = b;
                     frame_pos++;
                  end
               end else begin
                  phase_now = RX_IDLE;
                  frame_pos = 0;
               end
            end
            default: ;
         endcase
      end
      res.rx_state = phase_now;
      return res;
   endfunction

   function automatic void note_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         flag_cfg   = FLAG_BYTE_RST;
         addr_cfg   = ADDRESS_BYTE_RST;
         wanted_cfg = '0;
         count_cfg  = '0;
         mode_cfg   = MODE_SUPERVISION;
         phase_now  = RX_IDLE;
         ctrl_seen  = '0;
         frame_pos  = 0;
         match_idx  = '0;
         expected_rsp_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FLAG_BYTE:    flag_cfg = csr_data[7:0];
               CSR_ADDRESS_BYTE: addr_cfg = csr_data[7:0];
               CSR_WANTED_BYTES: wanted_cfg = csr_data;
               CSR_WANTED_COUNT: count_cfg = csr_data[3:0];
               CSR_FRAME_MODE:   mode_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               $error("response with no request outstanding: rx_state %0d",
                      rsp_payload.rx_state);
            end else begin
               want = expected_rsp_q.pop_front();
               note_field("rx_state", want.rx_state, rsp_payload.rx_state);
               note_field("store_valid", want.store_valid, rsp_payload.store_valid);
               note_field("store_pos", want.store_pos, rsp_payload.store_pos);
               note_field("store_byte", want.store_byte, rsp_payload.store_byte);
               note_field("frame_done", want.frame_done, rsp_payload.frame_done);
               note_field("control_index", want.control_index, rsp_payload.control_index);
               note_field("payload_length", want.payload_length,
                          rsp_payload.payload_length);
               note_field("overflow", want.overflow, rsp_payload.overflow);
            end
         end
         if (req_valid && !req_stall) begin
            want = advance_receiver(req_payload);
            expected_rsp_q.push_back(want);
            request_count++;
            if (want.frame_done) frame_count++;
            if (want.overflow) overflow_count++;
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the link frame receiver.
// A directed pass walks every header phase, restart, done hold, the check
// byte equal to the flag, an oversized wanted count, mid-frame mode changes
// and a payload long enough to fill the store. Random frames, broken frames
// and noise follow under four handshake mixes, with a long receiver
// hold-off to back the pipe up. lfr_checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
   import lfr_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int LONG_PAYLOAD    = 1025;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatch_count;
   int pending_count;
   int request_count;
   int frame_count;
   int overflow_count;

   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  pressure_go = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  settings_used = 0;

   // register values last written, used to build well-formed frames
   logic [7:0]  cur_flag = FLAG_BYTE_RST;
   logic [7:0]  cur_addr = ADDRESS_BYTE_RST;
   logic [63:0] cur_wanted = '0;
   logic [3:0]  cur_count = '0;
   logic        cur_mode = MODE_SUPERVISION;

   link_frame_receiver_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   lfr_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .request_count  (request_count),
      .frame_count    (frame_count),
      .overflow_count (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (pressure_go && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_req(input logic cmd, input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= req_payload_type'({cmd, b});
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic put(input logic [7:0] b);
      send_req(CMD_BYTE, b);
   endtask

   task automatic restart();
      send_req(CMD_RESTART, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // Only called with nothing in flight.
   task automatic program_regs(input logic [7:0] f, input logic [7:0] a,
                               input logic [63:0] w, input logic [3:0] c, input logic m);
      csr_put(CSR_FLAG_BYTE, 64'(f));
      csr_put(CSR_ADDRESS_BYTE, 64'(a));
      csr_put(CSR_WANTED_BYTES, w);
      csr_put(CSR_WANTED_COUNT, 64'(c));
      csr_put(CSR_FRAME_MODE, 64'(m));
      csr_write <= 1'b0;
      cur_flag = f;
      cur_addr = a;
      cur_wanted = w;
      cur_count = c;
      cur_mode = m;
      settings_used++;
   endtask

   task automatic random_settings();
      logic [7:0]  f;
      logic [7:0]  a;
      logic [63:0] w;
      logic [3:0]  c;
      f = 8'($urandom);
      a = 8'($urandom);
      if (a == f) a = ~f;
      w = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       c = 4'd0;
         1:       c = 4'($urandom_range(15, 9));
         default: c = 4'($urandom_range(8, 1));
      endcase
      program_regs(f, a, w, c, 1'($urandom_range(1)));
   endtask

   // Well-formed frame from the current registers, optionally with one
   // byte corrupted; then usually a restart to leave the done hold.
   task automatic send_frame(input bit broken);
      logic [7:0] seq[$];
      logic [7:0] ctl;
      logic [7:0] p;
      int         slots;
      int         len;
      int         spot;
      slots = (cur_count > 8) ? 8 : int'(cur_count);
      if (slots == 0) ctl = 8'($urandom);
      else begin
         spot = $urandom_range(slots - 1);
         ctl = cur_wanted[8*spot +: 8];
      end
      seq.push_back(cur_flag);
      if ($urandom_range(7) == 0) seq.push_back(cur_flag);
      seq.push_back(cur_addr);
      seq.push_back(ctl);
      seq.push_back(cur_addr ^ ctl);
      if (cur_mode == MODE_INFORMATION) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
         repeat (len) begin
            p = 8'($urandom);
            if (p == cur_flag) p = p ^ 8'h01;
            seq.push_back(p);
         end
      end
      seq.push_back(cur_flag);
      if (broken) begin
         spot = $urandom_range(seq.size() - 1);
         seq[spot] = 8'($urandom);
      end
      foreach (seq[i]) put(seq[i]);
      if ($urandom_range(3) == 0) put(8'($urandom));
      if ($urandom_range(9) != 0) restart();
   endtask

   task automatic run_traffic(input int n);
      int start;
      int pick;
      start = request_count;
      while (request_count - start < n) begin
         pick = $urandom_range(99);
         if (pick < 70) send_frame(1'b0);
         else if (pick < 88) send_frame(1'b1);
         else if (pick < 96) put(8'($urandom));
         else restart();
      end
   endtask

   initial begin
      logic [7:0] p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: no wanted byte, so the control byte is refused
      put(8'h7E); put(8'h03); put(8'h00);
      wait_drained();

      // count above the table size acts as eight entries
      program_regs(8'h7E, 8'h03, 64'h7D11_2233_4455_6600, 4'd15, MODE_SUPERVISION);
      restart(); put(8'h00);
      put(8'h7E); put(8'h7E); put(8'h55);
      put(8'h7E); put(8'h03); put(8'h7E); put(8'h03); put(8'h99);
      // check byte equals the flag, then closing flag and done hold
      put(8'h7E); put(8'h03); put(8'h7D); put(8'h7E); put(8'h7E); put(8'h12);
      restart();
      put(8'h7E); put(8'h03); put(8'h00); put(8'h7E); put(8'h03); put(8'h00); put(8'hFF);
      put(8'h7E); put(8'h03); put(8'h11); put(8'h12); put(8'h42);
      wait_drained();

      program_regs(8'h7E, 8'h03, 64'h7D11_2233_4455_6600, 4'd8, MODE_INFORMATION);
      put(8'h7E); put(8'h03); put(8'h11); put(8'h12);
      put(8'hFF); put(8'h00); put(8'hAB); put(8'h7E);
      restart();

      // mode switched while the frame is open
      put(8'h7E); put(8'h03); put(8'h66); put(8'h65); put(8'hAA); put(8'hBB);
      wait_drained();
      program_regs(8'h7E, 8'h03, 64'h7D11_2233_4455_6600, 4'd8, MODE_SUPERVISION);
      put(8'h7E);
      restart();
      put(8'h7E); put(8'h03); put(8'h55); put(8'h56);
      wait_drained();
      program_regs(8'h7E, 8'h03, 64'h7D11_2233_4455_6600, 4'd8, MODE_INFORMATION);
      put(8'hCC); put(8'hDD); put(8'h7E);
      restart();
      put(8'h7E); put(8'h03); put(8'h22); put(8'h21); put(8'hAA);
      wait_drained();
      program_regs(8'h7E, 8'h03, 64'h7D11_2233_4455_6600, 4'd8, MODE_SUPERVISION);
      put(8'hBB);
      wait_drained();

      // payload runs past the store size
      program_regs(8'h7E, 8'h03, 64'h7D11_2233_4455_6600, 4'd8, MODE_INFORMATION);
      put(8'h7E); put(8'h03); put(8'h33); put(8'h30);
      repeat (LONG_PAYLOAD) begin
         p = 8'($urandom);
         if (p == 8'h7E) p = 8'h7F;
         put(p);
      end
      put(8'h7E);
      restart();
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin idle_pct = 0;  stall_pct <= 0;  end
            1:       begin idle_pct = 79; stall_pct <= 0;  end
            2:       begin idle_pct = 0;  stall_pct <= 79; end
            default: begin idle_pct = 7;  stall_pct <= 7;  end
         endcase
         for (int sub = 0; sub < 4; sub++) begin
            if (ph == 0 && sub == 0)
               program_regs(8'h00, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, MODE_INFORMATION);
            else if (ph == 1 && sub == 0)
               program_regs(8'hFF, 8'h00, 64'h0, 4'd15, MODE_SUPERVISION);
            else
               random_settings();
            if (ph == 0 && sub == 2) pressure_go <= 1'b1;
            run_traffic(10);
            wait_drained();
         end
      end

      $display("Sent %0d requests over four handshake mixes and %0d register settings.",
               request_count, settings_used);
      $display("%0d frames closed, %0d payload bytes dropped at a full store.",
               frame_count, overflow_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lfr_pkg.sv
hw/rtl/link_frame_receiver_top.sv
verif/lfr_checker.sv
verif/testbench.sv
